// File: src/tte_pkg.sv
// Shared constants and codes for the transposition table engine.
`default_nettype none

package tte_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES_DEFAULT = 4096;

  // Field widths
  localparam int MODE_W  = 1;
  localparam int KEY_W   = 64;
  localparam int DEPTH_W = 8;
  localparam int SCORE_W = 16;
  localparam int PLY_W   = 8;
  localparam int KIND_W  = 2;
  localparam int MOVE_W  = 8;

  // Configuration registers
  localparam int MASK_W      = 12;
  localparam int THR_W       = 15;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 15;

  localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_MASK    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WIN_THRESHOLD = 1'd1;

  localparam logic [THR_W-1:0] WIN_THRESHOLD_RESET = 15'd32000;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_PROBE = 1'b0;
  localparam logic [MODE_W-1:0] MODE_SAVE  = 1'b1;

  // Bound kinds
  localparam logic [KIND_W-1:0] BOUND_EXACT = 2'd0;
  localparam logic [KIND_W-1:0] BOUND_UPPER = 2'd1;
  localparam logic [KIND_W-1:0] BOUND_LOWER = 2'd2;

endpackage

`default_nettype wire

// File: src/tte_if.sv
// Request and result channel interfaces of the transposition table engine.
`default_nettype none

interface tte_req_if
  import tte_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic [KEY_W-1:0]          position_key;
  logic [DEPTH_W-1:0]        search_depth;
  logic signed [SCORE_W-1:0] alpha_bound;
  logic signed [SCORE_W-1:0] beta_bound;
  logic [PLY_W-1:0]          ply_from_root;
  logic signed [SCORE_W-1:0] score_in;
  logic [KIND_W-1:0]         bound_kind;
  logic [MOVE_W-1:0]         move_in;

  modport source (
    output valid, mode, position_key, search_depth, alpha_bound, beta_bound,
           ply_from_root, score_in, bound_kind, move_in,
    input  ready
  );

  modport sink (
    input  valid, mode, position_key, search_depth, alpha_bound, beta_bound,
           ply_from_root, score_in, bound_kind, move_in,
    output ready
  );
endinterface

interface tte_res_if
  import tte_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic                      score_found;
  logic signed [SCORE_W-1:0] score_out;
  logic                      move_found;
  logic [MOVE_W-1:0]         move_out;

  modport source (
    output valid, score_found, score_out, move_found, move_out,
    input  ready
  );

  modport sink (
    input  valid, score_found, score_out, move_found, move_out,
    output ready
  );
endinterface

`default_nettype wire

// File: src/transposition_table_engine_top.sv
// Transposition table engine: direct-mapped table with probe and save requests.
//
// One request per cycle is sustained while the result channel is ready. A
// request reads its table slot in the cycle it is accepted; the lookup stage
// then compares the key, builds the result and, once the output register can
// take it, writes a save back to the same single-port-write memory, with the
// write forwarded to a following request on the same slot. The result is held
// in an output register, and the next request is taken while it waits. After
// reset a clearing pass walks all TABLE_ENTRIES slots, one per cycle, before
// the first request is taken; configuration writes are taken during that pass.
`default_nettype none

module transposition_table_engine_top
  import tte_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  tte_req_if.sink                req,
  tte_res_if.source              res
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [MOVE_W-1:0]  move;
    logic [DEPTH_W-1:0] depth;
    logic [KIND_W-1:0]  kind;
    logic [SCORE_W-1:0] score;
  } entry_t;

  typedef struct packed {
    logic               score_found;
    logic [SCORE_W-1:0] score_out;
    logic               move_found;
    logic [MOVE_W-1:0]  move_out;
  } result_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

  // Configuration registers
  logic [MASK_W-1:0] index_mask;
  logic [THR_W-1:0]  win_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      index_mask    <= '0;
      win_threshold <= WIN_THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INDEX_MASK:    index_mask    <= cfg_wdata[MASK_W-1:0];
        CFG_WIN_THRESHOLD: win_threshold <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Clearing pass after reset
  state_t           state;
  logic [IDX_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + IDX_W'(1);
          if (&clr_addr) state <= ST_RUN;
        end
        ST_RUN: ;
        default: state <= ST_CLEAR;
      endcase
    end
  end

  // Handshake control
  logic    b_valid;
  logic    out_valid;
  logic    b_advance;
  logic    in_fire;
  result_t out_q;

  assign b_advance = b_valid && (!out_valid || res.ready);
  assign req.ready = (state == ST_RUN) && (!b_valid || b_advance);
  assign in_fire   = req.valid && req.ready;

  // Slot select: key masked by the register, limited to the table size
  logic [IDX_W-1:0] mask_ext;
  logic [IDX_W-1:0] req_slot;

  always_comb begin
    mask_ext = '0;
    for (int i = 0; i < IDX_W && i < MASK_W; i++) begin
      mask_ext[i] = index_mask[i];
    end
  end

  assign req_slot = req.position_key[IDX_W-1:0] & mask_ext;

  // Win score push, computed from the request fields before the lookup
  logic [SCORE_W:0]          req_mag;
  logic signed [SCORE_W+1:0] score_wide;
  logic signed [SCORE_W+1:0] score_push;
  logic signed [SCORE_W+1:0] score_clamp;
  logic [SCORE_W+1:0]        ply_ext;
  logic [SCORE_W-1:0]        req_store_score;

  always_comb begin
    req_mag = req.score_in[SCORE_W-1]
            ? ((SCORE_W+1)'(0) - {req.score_in[SCORE_W-1], req.score_in})
            : {1'b0, req.score_in};
    score_wide = $signed({{2{req.score_in[SCORE_W-1]}}, req.score_in});
    ply_ext    = {{(SCORE_W+2-PLY_W){1'b0}}, req.ply_from_root};
    score_push = req.score_in[SCORE_W-1] ? (score_wide - $signed(ply_ext))
                                         : (score_wide + $signed(ply_ext));
    priority if (score_push > 18'sd32767) begin
      score_clamp = 18'sd32767;
    end else if (score_push < -18'sd32768) begin
      score_clamp = -18'sd32768;
    end else begin
      score_clamp = score_push;
    end
    req_store_score = (req_mag > {2'b00, win_threshold})
                    ? score_clamp[SCORE_W-1:0] : req.score_in;
  end

  // Lookup stage registers
  logic [MODE_W-1:0]         b_mode;
  logic [KEY_W-1:0]          b_key;
  logic [DEPTH_W-1:0]        b_depth;
  logic signed [SCORE_W-1:0] b_alpha;
  logic signed [SCORE_W-1:0] b_beta;
  logic [SCORE_W-1:0]        b_score;
  logic [KIND_W-1:0]         b_kind;
  logic [MOVE_W-1:0]         b_move;
  logic [IDX_W-1:0]          b_slot;
  logic                      b_enabled;
  logic                      b_fwd;
  entry_t                    b_fwd_word;

  // Memory and write-back
  entry_t           mem [TABLE_ENTRIES];
  entry_t           rd_word;
  entry_t           cur;
  entry_t           b_wdata;
  entry_t           mem_wdata;
  logic [IDX_W-1:0] mem_waddr;
  logic             mem_we;
  logic             b_we;
  logic             hit;
  result_t          res_next;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (in_fire) rd_word <= mem[req_slot];
  end

  always_comb begin
    cur = b_fwd ? b_fwd_word : rd_word;
    hit = b_enabled && cur.valid && (cur.key == b_key);

    // Probe result
    res_next = '0;
    if (b_mode == MODE_PROBE && hit) begin
      res_next.move_found = 1'b1;
      res_next.move_out   = cur.move;
      if (cur.depth >= b_depth) begin
        unique case (cur.kind)
          BOUND_EXACT: begin
            res_next.score_found = 1'b1;
            res_next.score_out   = cur.score;
          end
          BOUND_UPPER: begin
            if ($signed(cur.score) <= b_alpha) begin
              res_next.score_found = 1'b1;
              res_next.score_out   = b_alpha;
            end
          end
          BOUND_LOWER: begin
            if ($signed(cur.score) >= b_beta) begin
              res_next.score_found = 1'b1;
              res_next.score_out   = b_beta;
            end
          end
          default: ;
        endcase
      end
    end

    // Save: replace unless the same key sits at greater depth
    b_we = b_advance && (b_mode == MODE_SAVE) && b_enabled
        && !(hit && (cur.depth > b_depth));
    b_wdata = '{valid: 1'b1, key: b_key, move: b_move, depth: b_depth,
                kind: b_kind, score: b_score};

    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = b_we;
      mem_waddr = b_slot;
      mem_wdata = b_wdata;
    end
  end

  // Lookup stage payload, with forwarding of a same-cycle write
  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_mode     <= req.mode;
      b_key      <= req.position_key;
      b_depth    <= req.search_depth;
      b_alpha    <= req.alpha_bound;
      b_beta     <= req.beta_bound;
      b_score    <= req_store_score;
      b_kind     <= req.bound_kind;
      b_move     <= req.move_in;
      b_slot     <= req_slot;
      b_enabled  <= (index_mask != '0);
      b_fwd      <= b_we && (b_slot == req_slot);
      b_fwd_word <= b_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (in_fire) begin
      b_valid <= 1'b1;
    end else if (b_advance) begin
      b_valid <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_advance) out_q <= res_next;
  end

  assign res.valid       = out_valid;
  assign res.score_found = out_q.score_found;
  assign res.score_out   = out_q.score_out;
  assign res.move_found  = out_q.move_found;
  assign res.move_out    = out_q.move_out;

endmodule

`default_nettype wire

// File: src/tte_checker.sv
// Port-level checks of the transposition table engine, bound to the top level.
`default_nettype none

module tte_checker
  import tte_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      score_found,
  input logic signed [SCORE_W-1:0] score_out,
  input logic                      move_found,
  input logic [MOVE_W-1:0]         move_out
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] outstanding;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Requests in flight: accepted and not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      unique case ({in_acc, out_acc})
        2'b10:   outstanding <= outstanding + 2'd1;
        2'b01:   outstanding <= outstanding - 2'd1;
        default: outstanding <= outstanding;
      endcase
    end
  end

  // At most one request in the lookup stage and one in the output register
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    outstanding != 2'd3)
    else $error("more than two requests in flight");

  // A result is never shown without a request behind it
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> outstanding != 2'd0)
    else $error("result without an accepted request");

  // A usable score only comes with a matched move
  a_score_needs_move: assert property (@(posedge clk) disable iff (rst)
    out_valid && score_found |-> move_found)
    else $error("score found without key match");

  // Fields not found read as zero
  a_zero_when_missing: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (score_found || score_out == '0) && (move_found || move_out == '0))
    else $error("nonzero field on a miss");

  // A stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(score_found)
      && $stable(score_out) && $stable(move_found) && $stable(move_out))
    else $error("result changed while stalled");

endmodule

bind transposition_table_engine_top tte_checker u_tte_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (req.valid),
  .in_ready    (req.ready),
  .out_valid   (res.valid),
  .out_ready   (res.ready),
  .score_found (res.score_found),
  .score_out   (res.score_out),
  .move_found  (res.move_found),
  .move_out    (res.move_out)
);

`default_nettype wire
